FILE: hdl/assert_macros.svh
// Assertion helpers for the module that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define ACUR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication, reset masks the check.
`define ACUR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

FILE: hdl/acur_pkg.sv
package acur_pkg;

  localparam int KEY_BYTES   = 16;
  localparam int BLOCK_BYTES = 16;
  localparam int ROUNDS      = 10;
  localparam int KEY_W       = KEY_BYTES * 8;
  localparam int BLOCK_W     = BLOCK_BYTES * 8;

  typedef enum logic [1:0] {
    FN_RESTART = 2'd0,
    FN_BYTE    = 2'd1,
    FN_WORD    = 2'd2,
    FN_UNIFORM = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    RES_WORD = 2'd0,
    RES_HIGH = 2'd1,
    RES_ZERO = 2'd2
  } res_sel_t;

  localparam logic [2:0] CFG_KEY_HIGH   = 3'd0;
  localparam logic [2:0] CFG_KEY_LOW    = 3'd1;
  localparam logic [2:0] CFG_NONCE_HIGH = 3'd2;
  localparam logic [2:0] CFG_NONCE_LOW  = 3'd3;
  localparam logic [2:0] CFG_CLR_TAIL   = 3'd4;

  typedef struct packed {
    logic     latch;
    logic     restart;
    logic     div_start;
    logic     aes_start;
    logic     take_byte;
    logic     word_clear;
    logic     mul;
    logic     load_out;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic aes_done;
    logic div_done;
    logic reject;
    logic bound_zero;
  } sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] v;
    case (rnd)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [KEY_W-1:0] key_next(input logic [KEY_W-1:0] rk,
                                                input logic [7:0] rc);
    logic [31:0] w [4];
    logic [31:0] t;
    for (int i = 0; i < 4; i++) w[i] = rk[KEY_W-1-32*i -: 32];
    t = {SBOX[w[3][23:16]], SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]}
        ^ {rc, 24'h000000};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    return {w[0], w[1], w[2], w[3]};
  endfunction

  function automatic logic [BLOCK_W-1:0] aes_round(input logic [BLOCK_W-1:0] s,
                                                   input logic [KEY_W-1:0] rk,
                                                   input logic last);
    logic [7:0] b  [16];
    logic [7:0] n  [16];
    logic [7:0] mc [16];
    logic [7:0] t;
    logic [BLOCK_W-1:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[BLOCK_W-1-8*i -: 8];
    // sub bytes and shift rows together
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        n[r+4*c] = SBOX[b[r+4*((c+r)&3)]];
    for (int c = 0; c < 4; c++) begin
      t = n[4*c] ^ n[4*c+1] ^ n[4*c+2] ^ n[4*c+3];
      for (int k = 0; k < 4; k++)
        mc[4*c+k] = n[4*c+k] ^ t ^ xtime(n[4*c+k] ^ n[4*c+((k+1)&3)]);
    end
    for (int i = 0; i < 16; i++)
      o[BLOCK_W-1-8*i -: 8] = (last ? n[i] : mc[i]) ^ rk[KEY_W-1-8*i -: 8];
    return o;
  endfunction

endpackage

FILE: hdl/acur_aes.sv
module acur_aes
  import acur_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [KEY_W-1:0]   key,
  input  logic [BLOCK_W-1:0] blk_in,
  output logic               done,
  output logic [BLOCK_W-1:0] blk_out
);

  logic [BLOCK_W-1:0] s_r, s_nxt;
  logic [KEY_W-1:0]   rk_r, rk_nxt;
  logic [3:0]         round_r;
  logic               busy_r;
  logic               done_r;

  always_comb begin
    rk_nxt = key_next(rk_r, rcon(round_r));
    s_nxt  = aes_round(s_r, rk_nxt, round_r == 4'(ROUNDS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      round_r <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        round_r <= 4'd1;
      end else if (busy_r) begin
        round_r <= round_r + 4'd1;
        if (round_r == 4'(ROUNDS)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s_r  <= blk_in ^ key;
      rk_r <= key;
    end else if (busy_r) begin
      s_r  <= s_nxt;
      rk_r <= rk_nxt;
    end
  end

  assign done    = done_r;
  assign blk_out = s_r;

endmodule

FILE: hdl/acur_datapath.sv
module acur_datapath
  import acur_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic [31:0] in_bound,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [31:0] out_data
);

  logic [63:0]        key_high_r, key_low_r, nonce_high_r, nonce_low_r;
  logic               clr_tail_r;
  logic [BLOCK_W-1:0] ctr_r;
  logic [7:0]         ks_r [BLOCK_BYTES];
  logic [4:0]         used_r;
  logic [31:0]        word_r, bound_r, dvd_r, out_r;
  logic [32:0]        rem_r, rem_sh;
  logic [5:0]         dcnt_r;
  logic [63:0]        prod_r;
  logic               aes_done;
  logic [BLOCK_W-1:0] aes_out;

  acur_aes u_aes (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.aes_start),
    .key     ({key_high_r, key_low_r}),
    .blk_in  (ctr_r),
    .done    (aes_done),
    .blk_out (aes_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r   <= '0;
      key_low_r    <= '0;
      nonce_high_r <= '0;
      nonce_low_r  <= '0;
      clr_tail_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_HIGH:   key_high_r   <= cfg_wdata;
        CFG_KEY_LOW:    key_low_r    <= cfg_wdata;
        CFG_NONCE_HIGH: nonce_high_r <= cfg_wdata;
        CFG_NONCE_LOW:  nonce_low_r  <= cfg_wdata;
        CFG_CLR_TAIL:   clr_tail_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // counter and keystream buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r  <= '0;
      used_r <= 5'(BLOCK_BYTES);
      for (int i = 0; i < BLOCK_BYTES; i++) ks_r[i] <= 8'h00;
    end else if (cmd.restart) begin
      ctr_r  <= {nonce_high_r,
                 clr_tail_r ? {nonce_low_r[63:16], 16'h0000} : nonce_low_r};
      used_r <= 5'(BLOCK_BYTES);
      for (int i = 0; i < BLOCK_BYTES; i++) ks_r[i] <= 8'h00;
    end else if (aes_done) begin
      ctr_r  <= ctr_r + BLOCK_W'(1);
      used_r <= 5'd0;
      for (int i = 0; i < BLOCK_BYTES; i++) ks_r[i] <= aes_out[BLOCK_W-1-8*i -: 8];
    end else if (cmd.take_byte) begin
      used_r <= used_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.word_clear)
      word_r <= '0;
    else if (cmd.take_byte)
      word_r <= {word_r[23:0], ks_r[used_r[3:0]]};
    if (cmd.latch) bound_r <= in_bound;
    if (cmd.mul)   prod_r  <= 64'(word_r) * 64'(bound_r);
    if (cmd.load_out) begin
      case (cmd.res_sel)
        RES_WORD: out_r <= word_r;
        RES_HIGH: out_r <= prod_r[63:32];
        RES_ZERO: out_r <= '0;
        default:  out_r <= '0;
      endcase
    end
  end

  // restoring divider for (-bound) mod bound, one quotient bit a cycle
  assign rem_sh = {rem_r[31:0], dvd_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= 6'd32;
    end else if (dcnt_r != 6'd0) begin
      dcnt_r <= dcnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      dvd_r <= 32'd0 - in_bound;
    end else if (dcnt_r != 6'd0) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      if (rem_sh >= {1'b0, bound_r})
        rem_r <= rem_sh - {1'b0, bound_r};
      else
        rem_r <= rem_sh;
    end
  end

  always_comb begin
    sts.empty      = used_r[4];
    sts.aes_done   = aes_done;
    sts.div_done   = (dcnt_r == 6'd0);
    sts.reject     = prod_r[31:0] < rem_r[31:0];
    sts.bound_zero = (in_bound == 32'd0);
  end

  assign out_data = out_r;

endmodule

FILE: hdl/acur_ctrl.sv
module acur_ctrl
  import acur_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] in_func,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  sts_t       sts,
  output cmd_t       cmd
);

`include "assert_macros.svh"

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_BYTE = 7'b0000100,
    ST_AES  = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_CMP  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t   state_r, state_nxt;
  func_t    func_r, func_nxt;
  res_sel_t sel_r, sel_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    sel_nxt       = sel_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.res_sel   = sel_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          func_nxt  = func_t'(in_func);
          sel_nxt   = RES_WORD;
          case (func_t'(in_func))
            FN_RESTART: cmd.restart = 1'b1;
            FN_BYTE: begin
              cmd.word_clear = 1'b1;
              cnt_nxt        = 3'd1;
              state_nxt      = ST_BYTE;
            end
            FN_WORD: begin
              cmd.word_clear = 1'b1;
              cnt_nxt        = 3'd4;
              state_nxt      = ST_BYTE;
            end
            default: begin
              if (sts.bound_zero) begin
                sel_nxt   = RES_ZERO;
                state_nxt = ST_DONE;
              end else begin
                cmd.div_start = 1'b1;
                state_nxt     = ST_DIV;
              end
            end
          endcase
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.word_clear = 1'b1;
          cnt_nxt        = 3'd4;
          state_nxt      = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (sts.empty) begin
          cmd.aes_start = 1'b1;
          state_nxt     = ST_AES;
        end else begin
          cmd.take_byte = 1'b1;
          cnt_nxt       = cnt_r - 3'd1;
          if (cnt_r == 3'd1)
            state_nxt = (func_r == FN_UNIFORM) ? ST_MUL : ST_DONE;
        end
      end
      ST_AES: begin
        if (sts.aes_done) state_nxt = ST_BYTE;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // draw again while the low product half falls below the threshold
        if (sts.reject) begin
          cmd.word_clear = 1'b1;
          cnt_nxt        = 3'd4;
          state_nxt      = ST_BYTE;
        end else begin
          sel_nxt   = RES_HIGH;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      func_r      <= FN_RESTART;
      sel_r       <= RES_WORD;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      func_r      <= func_nxt;
      sel_r       <= sel_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `ACUR_ASSERT(a_take_nonempty, cmd.take_byte |-> !sts.empty, "byte taken from empty buffer")
  `ACUR_ASSERT(a_aes_done_wait, sts.aes_done |-> (state_r == ST_AES), "refill done while not waiting")
  `ACUR_ASSERT(a_load_free, cmd.load_out |-> (!out_valid_r || out_tready), "result overwritten")
  `ACUR_ASSERT_NEXT(a_out_set, cmd.load_out, out_valid_r, "loaded result not presented")

endmodule

FILE: hdl/aes_ctr_uniform_random_source_core.sv
// Channel   Direction  tdata              tuser
// in_       slave      [31:0] bound       [1:0] func
// out_      master     [31:0] random_value -
// cfg_      write      [63:0] value, index 0..4 (writes take effect at once)
//
// One request at a time. Each keystream refill runs on the one-round-per-cycle
// AES engine. A uniform request runs the bit-serial modulo, then for each draw
// four bytes, a multiply and a compare, and then finishes.
// Reset (rst_n low, synchronous) zeroes key, nonce and counter and empties the buffer.
// A held result does not block the next request; it waits only at completion.
module aes_ctr_uniform_random_source_core
  import acur_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] bound
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] random_value
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  acur_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  acur_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_bound  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_tdata)
  );

endmodule

FILE: tb/aes_ctr_uniform_random_source_checker.sv
`timescale 1ns / 100ps

module aes_ctr_uniform_random_source_checker
  import acur_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] bound
  input  logic [1:0]  in_tuser,   // [1:0] func
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] random_value
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          mismatch_count,
  output int          values_pending
);

  logic [127:0] key_reg;
  logic [127:0] nonce_reg;
  logic         clear_tail;
  logic [127:0] ctr;
  logic [127:0] keystream;
  int           used;
  logic [31:0]  value_q[$];

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] next_round_key(input logic [127:0] rk,
                                                  input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] encrypt(input logic [127:0] k, input logic [127:0] pt);
    logic [7:0]   st [16];
    logic [7:0]   sh [16];
    logic [7:0]   a0, a1, a2, a3, t;
    logic [127:0] rk, s;
    logic [7:0]   rc;
    rk = k;
    s = pt ^ rk;
    rc = 8'h01;
    for (int rnd = 1; rnd <= 10; rnd++) begin
      rk = next_round_key(rk, rc);
      rc = gf_double(rc);
      for (int i = 0; i < 16; i++) st[i] = s[127-8*i -: 8];
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          sh[r+4*c] = SBOX[st[r+4*((c+r)%4)]];
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
          t = a0 ^ a1 ^ a2 ^ a3;
          sh[4*c]   = a0 ^ t ^ gf_double(a0 ^ a1);
          sh[4*c+1] = a1 ^ t ^ gf_double(a1 ^ a2);
          sh[4*c+2] = a2 ^ t ^ gf_double(a2 ^ a3);
          sh[4*c+3] = a3 ^ t ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[127-8*i -: 8] = sh[i] ^ rk[127-8*i -: 8];
    end
    return s;
  endfunction

  function automatic logic [7:0] draw_byte();
    logic [7:0] b;
    if (used >= 16) begin
      keystream = encrypt(key_reg, ctr);
      ctr = ctr + 128'd1;
      used = 0;
    end
    b = keystream[127-8*used -: 8];
    used++;
    return b;
  endfunction

  function automatic logic [31:0] draw_word();
    logic [31:0] w;
    w = 32'd0;
    for (int i = 0; i < 4; i++) w = {w[23:0], draw_byte()};
    return w;
  endfunction

  function automatic logic [31:0] draw_uniform(input logic [31:0] bound);
    logic [31:0] thr;
    logic [63:0] prod;
    if (bound == 32'd0) return 32'd0;
    thr = (32'd0 - bound) % bound;
    do prod = {32'd0, draw_word()} * {32'd0, bound};
    while (prod[31:0] < thr);
    return prod[63:32];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      key_reg = '0;
      nonce_reg = '0;
      clear_tail = 1'b0;
      ctr = '0;
      keystream = '0;
      used = 16;
      value_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (value_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected value %h with nothing pending", out_tdata);
        end else begin
          if (out_tdata !== value_q[0]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("value mismatch: expected %h, got %h", value_q[0], out_tdata);
          end
          void'(value_q.pop_front());
        end
      end
      if (in_tvalid && in_tready) begin
        case (func_t'(in_tuser))
          FN_RESTART: begin
            ctr = clear_tail ? {nonce_reg[127:16], 16'h0000} : nonce_reg;
            keystream = '0;
            used = 16;
          end
          FN_BYTE:    value_q.push_back({24'd0, draw_byte()});
          FN_WORD:    value_q.push_back(draw_word());
          default:    value_q.push_back(draw_uniform(in_tdata));
        endcase
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_HIGH:   key_reg[127:64] = cfg_wdata;
          CFG_KEY_LOW:    key_reg[63:0] = cfg_wdata;
          CFG_NONCE_HIGH: nonce_reg[127:64] = cfg_wdata;
          CFG_NONCE_LOW:  nonce_reg[63:0] = cfg_wdata;
          CFG_CLR_TAIL:   clear_tail = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    values_pending = value_q.size();
  end

endmodule

FILE: tb/aes_ctr_uniform_random_source_core_test.sv
`timescale 1ns / 100ps

module aes_ctr_uniform_random_source_core_test;
  import acur_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  int          mismatch_count;
  int          values_pending;
  int          idle_cycles;
  int          burst_left;
  int          stall_left = 0;
  logic        stall_mode = 1'b0;

  aes_ctr_uniform_random_source_core dut (.*);

  aes_ctr_uniform_random_source_checker checker_i (.*);

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // receiver alternates between runs of stalling and runs of taking
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(1, 30);
    end else begin
      stall_left <= stall_left - 1;
    end
    out_tready <= stall_mode ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_request(input func_t f, input logic [31:0] bound);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tuser = f;
    in_tdata = bound;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // hold until drained, then give a restart time to finish inside the block
  task automatic wait_drained();
    while (values_pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic load_settings(input logic [63:0] kh, input logic [63:0] kl,
                               input logic [63:0] nh, input logic [63:0] nl,
                               input logic tail);
    wait_drained();
    write_reg(CFG_KEY_HIGH, kh);
    write_reg(CFG_KEY_LOW, kl);
    write_reg(CFG_NONCE_HIGH, nh);
    write_reg(CFG_NONCE_LOW, nl);
    write_reg(CFG_CLR_TAIL, {63'd0, tail});
  endtask

  function automatic logic [63:0] pick_reg();
    case ($urandom_range(0, 4))
      0:       return 64'd0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(0, 6))
      0:       return 32'd0;
      1:       return $urandom_range(1, 20);
      2:       return 32'h8000_0000 + $urandom_range(0, 3);
      3:       return 32'hffff_ffff - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FN_RESTART;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // draw from the reset counter under the zero key
    send_request(FN_BYTE, 32'd0);
    send_request(FN_WORD, 32'hffff_ffff);
    send_request(FN_UNIFORM, 32'd0);

    // all-ones counter wraps to zero; word spans two blocks
    load_settings('1, '1, '1, '1, 1'b0);
    write_reg(3'd5, 64'h0123_4567_89ab_cdef);
    write_reg(3'd7, '1);
    send_request(FN_RESTART, 32'd0);
    repeat (14) send_request(FN_BYTE, 32'd0);
    send_request(FN_WORD, 32'd0);
    send_request(FN_WORD, 32'd0);
    send_request(FN_UNIFORM, 32'd1);
    send_request(FN_UNIFORM, 32'hffff_ffff);
    send_request(FN_UNIFORM, 32'h8000_0001);
    send_request(FN_UNIFORM, 32'd0);

    load_settings(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c,
                  '1, '1, 1'b1);
    send_request(FN_RESTART, 32'd0);
    send_request(FN_WORD, 32'd0);
    send_request(FN_UNIFORM, 32'd3);

    for (int phase = 0; phase < 8; phase++) begin
      load_settings(pick_reg(), pick_reg(), pick_reg(), pick_reg(),
                    1'($urandom_range(0, 1)));
      send_request(FN_RESTART, 32'd0);
      for (int n = 0; n < 160; n++) begin
        case ($urandom_range(0, 19))
          0:              send_request(FN_RESTART, $urandom);
          1, 2, 3, 4, 5, 6: send_request(FN_BYTE, $urandom);
          7, 8, 9, 10, 11, 12: send_request(FN_WORD, $urandom);
          default:        send_request(FN_UNIFORM, pick_bound());
        endcase
      end
    end

    while (values_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
